// ----- hw/rtl/srp_pkg.sv -----
// ----------------------------------------------------------------------------
// srp_pkg
// Shared types and constants for the pixel-to-world ray generator.
// ----------------------------------------------------------------------------
package srp_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 15;
  localparam int VP_W       = 13;
  localparam int REG_W      = 16;
  localparam int OUT_W      = 16;
  localparam int CFG_IDX_W  = 3;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_VW = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CP = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SP = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CY = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SY = 3'd7;

  localparam logic [VP_W-1:0]  RST_VW = 13'd1024;
  localparam logic [VP_W-1:0]  RST_VH = 13'd768;
  localparam logic [REG_W-1:0] RST_HS = 16'd4096;
  localparam logic [REG_W-1:0] RST_VS = 16'd4096;
  localparam logic [REG_W-1:0] RST_CP = 16'd28378;
  localparam logic [REG_W-1:0] RST_SP = 16'd16384;
  localparam logic [REG_W-1:0] RST_CY = 16'd32767;
  localparam logic [REG_W-1:0] RST_SY = 16'd0;

  typedef struct packed {
    logic [COORD_BITS-1:0] screen_x;
    logic [COORD_BITS-1:0] screen_y;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] dir_x;
    logic signed [OUT_W-1:0] dir_y;
    logic signed [OUT_W-1:0] dir_z;
  } out_item_t;

endpackage

// ----- hw/rtl/screen_pixel_to_world_ray.sv -----
// ----------------------------------------------------------------------------
// screen_pixel_to_world_ray
// Pinhole camera primary ray generator: pixel in, unit world direction out.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_data with a pixel and pulse start; the item is taken on
//   any edge with start high and busy low. busy stays low, so one pixel per
//   clock is sustained.
//   Output: out_valid is high for one cycle with out_data holding the Q1.15
//   direction. The receiver cannot stall and has no ready; every item
//   comes out exactly once, in order.
//   Pipeline: the NDC dividers, the arithmetic stages, the 32-stage
//   square root, the normalization dividers and an output register; the
//   dividers are bit-serial and pipelined.
//   Config: cfg_index/cfg_data written on cfg_valid (cfg_ready is always
//   high). Write only while the pipe is empty; later stages read the live
//   registers.
//   Reset: synchronous, active low; clears all valid bits and loads the
//   register defaults (1024x768 viewport, unit scales, pitch ~30 deg).
// ----------------------------------------------------------------------------
module screen_pixel_to_world_ray #(
  parameter int FRAC_BITS = srp_pkg::FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  srp_pkg::in_item_t             in_data,
  output logic                          out_valid,
  output srp_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [srp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [srp_pkg::REG_W-1:0]     cfg_data
);

  localparam int NW   = srp_pkg::COORD_BITS + FRAC_BITS + 2; // NDC numerator
  localparam int PW_E = NW + 18;   // ndc * scale product
  localparam int EW   = NW + 6;    // eye-space x/y
  localparam int RP1  = EW + 16;   // pitch products
  localparam int RS1  = EW + 17;
  localparam int VW   = NW + 8;    // rotated components
  localparam int RP2  = VW + 16;   // yaw products
  localparam int RS2  = VW + 17;
  localparam int KW   = $clog2(VW + 1);
  localparam int SW   = 32;        // after range reduction, |v| <= 2^30
  localparam int MW   = 31;
  localparam int SQW  = 62;
  localparam int RADW = 64;
  localparam int LENW = 32;
  localparam int REMW = 34;
  localparam int NNW  = 47;        // |v|*2^15 + len/2
  localparam int DQW  = 17;
  localparam int VP_W = srp_pkg::VP_W;
  localparam int OW   = srp_pkg::OUT_W;

  // ---------------- config registers ----------------
  logic [VP_W-1:0]           vw_r, vh_r;
  logic [srp_pkg::REG_W-1:0] hs_r, vs_r, cp_r, sp_r, cy_r, sy_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vw_r <= srp_pkg::RST_VW;
      vh_r <= srp_pkg::RST_VH;
      hs_r <= srp_pkg::RST_HS;
      vs_r <= srp_pkg::RST_VS;
      cp_r <= srp_pkg::RST_CP;
      sp_r <= srp_pkg::RST_SP;
      cy_r <= srp_pkg::RST_CY;
      sy_r <= srp_pkg::RST_SY;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        srp_pkg::REG_VW: vw_r <= cfg_data[VP_W-1:0];
        srp_pkg::REG_VH: vh_r <= cfg_data[VP_W-1:0];
        srp_pkg::REG_HS: hs_r <= cfg_data;
        srp_pkg::REG_VS: vs_r <= cfg_data;
        srp_pkg::REG_CP: cp_r <= cfg_data;
        srp_pkg::REG_SP: sp_r <= cfg_data;
        srp_pkg::REG_CY: cy_r <= cfg_data;
        srp_pkg::REG_SY: sy_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- NDC division ----------------
  // num = 2*s*2^F + floor(size/2); a zero size counts as one
  logic [VP_W-1:0] w_eff, h_eff;
  logic [NW-1:0]   nx, ny, qx, qy;
  logic            dv_v;

  assign w_eff = (vw_r == '0) ? VP_W'(1) : vw_r;
  assign h_eff = (vh_r == '0) ? VP_W'(1) : vh_r;
  assign nx = (NW'(in_data.screen_x) << (FRAC_BITS + 1)) + NW'(w_eff >> 1);
  assign ny = (NW'(in_data.screen_y) << (FRAC_BITS + 1)) + NW'(h_eff >> 1);

  srp_div #(.NUM_W(NW), .DEN_W(VP_W), .Q_W(NW), .SIDE_W(1)) u_div_x (
    .clk, .rst_n,
    .in_valid (start && !busy),
    .in_num   (nx),
    .in_den   (w_eff),
    .in_side  (1'b0),
    .out_valid(dv_v),
    .out_quo  (qx),
    .out_side ()
  );

  srp_div #(.NUM_W(NW), .DEN_W(VP_W), .Q_W(NW), .SIDE_W(1)) u_div_y (
    .clk, .rst_n,
    .in_valid (start && !busy),
    .in_num   (ny),
    .in_den   (h_eff),
    .in_side  (1'b0),
    .out_valid(),
    .out_quo  (qy),
    .out_side ()
  );

  // ---------------- arithmetic pipe ----------------
  logic vb_r, vc_r, vd_r, ve_r, vf_r, vg_r, vh2_r, vi_r, vj_r, vk_r, vl_r;

  logic signed [NW:0]     sb_ndx_r, sb_ndy_r;
  logic signed [PW_E-1:0] sc_px_r, sc_py_r;
  logic signed [EW-1:0]   sd_ex_r, sd_ey_r;
  logic signed [RP1-1:0]  se_a_r, se_b_r;
  logic signed [EW-1:0]   se_ex_r;
  logic signed [VW-1:0]   sf_y1_r, sf_z1_r;
  logic signed [EW-1:0]   sf_ex_r;
  logic signed [RP2-1:0]  sg_a_r, sg_b_r, sg_c_r, sg_d_r;
  logic signed [VW-1:0]   sg_y1_r;
  logic signed [VW-1:0]   sh_x_r, sh_y_r, sh_z_r;
  logic signed [VW-1:0]   si_x_r, si_y_r, si_z_r;
  logic [VW-1:0]          si_m_r;
  logic signed [SW-1:0]   sj_x_r, sj_y_r, sj_z_r;
  logic [MW-1:0]          sk_mx_r, sk_my_r, sk_mz_r;
  logic [2:0]             sk_sg_r;
  logic [SQW-1:0]         sl_qx_r, sl_qy_r, sl_qz_r;
  logic [MW-1:0]          sl_mx_r, sl_my_r, sl_mz_r;
  logic [2:0]             sl_sg_r;

  logic signed [RS1-1:0]  y1_sum, z1_sum;
  logic signed [RS2-1:0]  x2_sum, z2_sum;
  logic [VW-1:0]          mag_x, mag_y, mag_z, m_xy, m_all;
  logic [KW-1:0]          k_sh;
  logic signed [SW-1:0]   ab_x, ab_y, ab_z;

  function automatic logic [VW-1:0] vmag(input logic signed [VW-1:0] v);
    return v[VW-1] ? VW'(-v) : VW'(v);
  endfunction

  // round-half-up arithmetic shift by k
  function automatic logic signed [SW-1:0] rnd_sh(input logic signed [VW-1:0] v,
                                                  input logic [KW-1:0] k);
    logic signed [VW:0] half;
    logic signed [VW:0] t;
    half = (k == '0) ? '0 : ((VW+1)'(1) <<< (k - 1'b1));
    t    = (VW+1)'(v) + half;
    return SW'(t >>> k);
  endfunction

  always_comb begin
    y1_sum = RS1'(se_a_r) - (RS1'($signed(sp_r)) <<< FRAC_BITS);
    z1_sum = -(RS1'($signed(cp_r)) <<< FRAC_BITS) - RS1'(se_b_r);
    x2_sum = RS2'(sg_a_r) - RS2'(sg_b_r);
    z2_sum = RS2'(sg_c_r) + RS2'(sg_d_r);
    mag_x  = vmag(sh_x_r);
    mag_y  = vmag(sh_y_r);
    mag_z  = vmag(sh_z_r);
    m_xy   = (mag_y > mag_x) ? mag_y : mag_x;
    m_all  = (mag_z > m_xy) ? mag_z : m_xy;
    // smallest k with m >> k below 2^30
    k_sh   = '0;
    for (int j = 30; j < VW; j++) begin
      if (si_m_r[j]) begin
        k_sh = KW'(j - 29);
      end
    end
    ab_x = sj_x_r[SW-1] ? -sj_x_r : sj_x_r;
    ab_y = sj_y_r[SW-1] ? -sj_y_r : sj_y_r;
    ab_z = sj_z_r[SW-1] ? -sj_z_r : sj_z_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0; vc_r <= 1'b0; vd_r <= 1'b0; ve_r <= 1'b0;
      vf_r <= 1'b0; vg_r <= 1'b0; vh2_r <= 1'b0; vi_r <= 1'b0;
      vj_r <= 1'b0; vk_r <= 1'b0; vl_r <= 1'b0;
    end else begin
      vb_r <= dv_v; vc_r <= vb_r; vd_r <= vc_r; ve_r <= vd_r;
      vf_r <= ve_r; vg_r <= vf_r; vh2_r <= vg_r; vi_r <= vh2_r;
      vj_r <= vi_r; vk_r <= vj_r; vl_r <= vk_r;
    end
  end

  always_ff @(posedge clk) begin
    // NDC in Q.F
    sb_ndx_r <= $signed({1'b0, qx}) - ((NW+1)'(1) <<< FRAC_BITS);
    sb_ndy_r <= ((NW+1)'(1) <<< FRAC_BITS) - $signed({1'b0, qy});
    // scale by tan terms (Q4.12)
    sc_px_r  <= sb_ndx_r * $signed({1'b0, hs_r});
    sc_py_r  <= sb_ndy_r * $signed({1'b0, vs_r});
    sd_ex_r  <= EW'((sc_px_r + (PW_E'(1) <<< 11)) >>> 12);
    sd_ey_r  <= EW'((sc_py_r + (PW_E'(1) <<< 11)) >>> 12);
    // inverse pitch, eye z = -1
    se_a_r   <= $signed(cp_r) * sd_ey_r;
    se_b_r   <= $signed(sp_r) * sd_ey_r;
    se_ex_r  <= sd_ex_r;
    sf_y1_r  <= VW'((y1_sum + (RS1'(1) <<< 14)) >>> 15);
    sf_z1_r  <= VW'((z1_sum + (RS1'(1) <<< 14)) >>> 15);
    sf_ex_r  <= se_ex_r;
    // inverse yaw
    sg_a_r   <= $signed(cy_r) * sf_ex_r;
    sg_b_r   <= $signed(sy_r) * sf_z1_r;
    sg_c_r   <= $signed(sy_r) * sf_ex_r;
    sg_d_r   <= $signed(cy_r) * sf_z1_r;
    sg_y1_r  <= sf_y1_r;
    sh_x_r   <= VW'((x2_sum + (RS2'(1) <<< 14)) >>> 15);
    sh_z_r   <= VW'((z2_sum + (RS2'(1) <<< 14)) >>> 15);
    sh_y_r   <= sg_y1_r;
    // range reduction
    si_x_r   <= sh_x_r;
    si_y_r   <= sh_y_r;
    si_z_r   <= sh_z_r;
    si_m_r   <= m_all;
    sj_x_r   <= rnd_sh(si_x_r, k_sh);
    sj_y_r   <= rnd_sh(si_y_r, k_sh);
    sj_z_r   <= rnd_sh(si_z_r, k_sh);
    sk_mx_r  <= ab_x[MW-1:0];
    sk_my_r  <= ab_y[MW-1:0];
    sk_mz_r  <= ab_z[MW-1:0];
    sk_sg_r  <= {sj_x_r[SW-1], sj_y_r[SW-1], sj_z_r[SW-1]};
    sl_qx_r  <= sk_mx_r * sk_mx_r;
    sl_qy_r  <= sk_my_r * sk_my_r;
    sl_qz_r  <= sk_mz_r * sk_mz_r;
    sl_mx_r  <= sk_mx_r;
    sl_my_r  <= sk_my_r;
    sl_mz_r  <= sk_mz_r;
    sl_sg_r  <= sk_sg_r;
  end

  // ---------------- integer square root, 2 bits per stage ----------------
  localparam int SQ_N = LENW;

  logic                rq_v_r    [0:SQ_N];
  logic [RADW-1:0]     rq_rad_r  [0:SQ_N];
  logic [REMW-1:0]     rq_rem_r  [0:SQ_N];
  logic [LENW-1:0]     rq_root_r [0:SQ_N];
  logic [3*MW-1:0]     rq_mag_r  [0:SQ_N];
  logic [2:0]          rq_sg_r   [0:SQ_N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rq_v_r[0] <= 1'b0;
    end else begin
      rq_v_r[0] <= vl_r;
    end
  end

  always_ff @(posedge clk) begin
    rq_rad_r[0]  <= RADW'(sl_qx_r) + RADW'(sl_qy_r) + RADW'(sl_qz_r);
    rq_rem_r[0]  <= '0;
    rq_root_r[0] <= '0;
    rq_mag_r[0]  <= {sl_mx_r, sl_my_r, sl_mz_r};
    rq_sg_r[0]   <= sl_sg_r;
  end

  for (genvar s = 0; s < SQ_N; s++) begin : g_sqrt
    logic [REMW+1:0] rem2;
    logic [REMW+1:0] trial;
    logic            take;

    assign rem2  = {rq_rem_r[s], rq_rad_r[s][RADW-1:RADW-2]};
    assign trial = (REMW+2)'({rq_root_r[s], 2'b01});
    assign take  = (rem2 >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rq_v_r[s+1] <= 1'b0;
      end else begin
        rq_v_r[s+1] <= rq_v_r[s];
      end
    end

    always_ff @(posedge clk) begin
      rq_rem_r[s+1]  <= take ? REMW'(rem2 - trial) : REMW'(rem2);
      rq_root_r[s+1] <= {rq_root_r[s][LENW-2:0], take};
      rq_rad_r[s+1]  <= {rq_rad_r[s][RADW-3:0], 2'b00};
      rq_mag_r[s+1]  <= rq_mag_r[s];
      rq_sg_r[s+1]   <= rq_sg_r[s];
    end
  end

  // ---------------- normalize: |v|*2^15 / len ----------------
  logic [LENW-1:0] len;
  logic [NNW-1:0]  num_x, num_y, num_z;
  logic [DQW-1:0]  qn_x, qn_y, qn_z;
  logic [1:0]      side_x;
  logic            side_y, side_z, dn_v;

  assign len   = rq_root_r[SQ_N];
  assign num_x = {NNW'(rq_mag_r[SQ_N][3*MW-1:2*MW]) << 15} + NNW'(len >> 1);
  assign num_y = {NNW'(rq_mag_r[SQ_N][2*MW-1:MW]) << 15} + NNW'(len >> 1);
  assign num_z = {NNW'(rq_mag_r[SQ_N][MW-1:0]) << 15} + NNW'(len >> 1);

  srp_div #(.NUM_W(NNW), .DEN_W(LENW), .Q_W(DQW), .SIDE_W(2)) u_norm_x (
    .clk, .rst_n,
    .in_valid (rq_v_r[SQ_N]),
    .in_num   (num_x),
    .in_den   (len),
    .in_side  ({(len == '0), rq_sg_r[SQ_N][2]}),
    .out_valid(dn_v),
    .out_quo  (qn_x),
    .out_side (side_x)
  );

  srp_div #(.NUM_W(NNW), .DEN_W(LENW), .Q_W(DQW), .SIDE_W(1)) u_norm_y (
    .clk, .rst_n,
    .in_valid (rq_v_r[SQ_N]),
    .in_num   (num_y),
    .in_den   (len),
    .in_side  (rq_sg_r[SQ_N][1]),
    .out_valid(),
    .out_quo  (qn_y),
    .out_side (side_y)
  );

  srp_div #(.NUM_W(NNW), .DEN_W(LENW), .Q_W(DQW), .SIDE_W(1)) u_norm_z (
    .clk, .rst_n,
    .in_valid (rq_v_r[SQ_N]),
    .in_num   (num_z),
    .in_den   (len),
    .in_side  (rq_sg_r[SQ_N][0]),
    .out_valid(),
    .out_quo  (qn_z),
    .out_side (side_z)
  );

  // clamp to [-32768, 32767]; a zero-length vector gives zero
  function automatic logic signed [OW-1:0] sat(input logic [DQW-1:0] q,
                                               input logic neg, input logic zero);
    logic [DQW-1:0] lim;
    lim = (q > (DQW'(1) << (OW - 1))) ? (DQW'(1) << (OW - 1)) : q;
    if (zero) begin
      return '0;
    end else if (neg) begin
      return OW'(DQW'(0) - lim);
    end else if (q > DQW'((1 << (OW - 1)) - 1)) begin
      return OW'((1 << (OW - 1)) - 1);
    end
    return OW'(q);
  endfunction

  logic               so_v_r;
  srp_pkg::out_item_t so_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      so_v_r <= 1'b0;
    end else begin
      so_v_r <= dn_v;
    end
  end

  always_ff @(posedge clk) begin
    so_r.dir_x <= sat(qn_x, side_x[0], side_x[1]);
    so_r.dir_y <= sat(qn_y, side_y, side_x[1]);
    so_r.dir_z <= sat(qn_z, side_z, side_x[1]);
  end

  assign out_valid = so_v_r;
  assign out_data  = so_r;

endmodule

// ----- hw/rtl/srp_div.sv -----
// ----------------------------------------------------------------------------
// srp_div
// Pipelined restoring divider, one quotient bit per stage. The top
// NUM_W-Q_W numerator bits must be below the divisor.
// ----------------------------------------------------------------------------
module srp_div #(
  parameter int NUM_W  = 47,
  parameter int DEN_W  = 32,
  parameter int Q_W    = 17,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [Q_W-1:0]    out_quo,
  output logic [SIDE_W-1:0] out_side
);

  localparam int HI_W = NUM_W - Q_W;

  logic              v_r    [0:Q_W];
  logic [DEN_W-1:0]  rem_r  [0:Q_W];
  logic [Q_W-1:0]    lo_r   [0:Q_W];
  logic [Q_W-1:0]    quo_r  [0:Q_W];
  logic [DEN_W-1:0]  den_r  [0:Q_W];
  logic [SIDE_W-1:0] side_r [0:Q_W];
  logic [DEN_W-1:0]  rem_ld;

  generate
    if (HI_W > 0) begin : g_hi
      assign rem_ld = DEN_W'(in_num[NUM_W-1:Q_W]);
    end else begin : g_nohi
      assign rem_ld = '0;
    end
  endgenerate

  // load stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0]  <= rem_ld;
    lo_r[0]   <= in_num[Q_W-1:0];
    quo_r[0]  <= '0;
    den_r[0]  <= in_den;
    side_r[0] <= in_side;
  end

  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           take;

    assign trial = {rem_r[s], lo_r[s][Q_W-1]};
    assign diff  = trial - {1'b0, den_r[s]};
    assign take  = (trial >= {1'b0, den_r[s]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s+1] <= 1'b0;
      end else begin
        v_r[s+1] <= v_r[s];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[s+1]  <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      lo_r[s+1]   <= {lo_r[s][Q_W-2:0], 1'b0};
      quo_r[s+1]  <= {quo_r[s][Q_W-2:0], take};
      den_r[s+1]  <= den_r[s];
      side_r[s+1] <= side_r[s];
    end
  end

  assign out_valid = v_r[Q_W];
  assign out_quo   = quo_r[Q_W];
  assign out_side  = side_r[Q_W];

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pixel-to-world ray generator.
// A directed table (register extremes, zero viewport, out-of-viewport pixels,
// degenerate trig) runs first. Random register phases with random pixels
// follow. Every accepted pixel is traced by an in-bench fixed-point camera
// model or takes the direction typed in its row, and each strobed direction is checked in order.
// ----------------------------------------------------------------------------
module tb;
  import srp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYC = 100;   // longer than the pipe latency
  localparam int WDOG_LIM  = 5000;  // cycles without a pixel, result or register write
  localparam int N_RAND    = 800;

  typedef enum logic {ROW_PIX, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [REG_W-1:0]     data;
    in_item_t             px;
    logic                 typed;   // expected direction written in the row
    out_item_t            dir;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_data = '0;
  logic out_valid;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_data = '0;

  // bench-side tag riding along with the pixel: use a typed expectation
  logic drv_typed = 1'b0;
  out_item_t drv_dir = '0;

  // camera registers as the bench believes them
  logic [VP_W-1:0]  vp_w, vp_h;
  logic [REG_W-1:0] h_scale, v_scale, cos_pitch, sin_pitch, cos_yaw, sin_yaw;

  out_item_t dir_expected[$];
  int unsigned pix_taken = 0, cfg_taken = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cyc = 0;

  always #4 clk = ~clk;

  screen_pixel_to_world_ray uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  function automatic longint rnd_sh(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;   // round half up
  endfunction

  function automatic longint absl(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint int_sqrt(longint n);
    longint r, b;
    r = 0;
    b = longint'(1) << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // scale one component to Q1.15 of the unit vector, saturating
  function automatic logic [OUT_W-1:0] unit_comp(longint v, longint len);
    longint q;
    q = (absl(v) * 32768 + len / 2) / len;
    if (v < 0) return OUT_W'(-((q > 32768) ? 64'sd32768 : q));
    return OUT_W'((q > 32767) ? 64'sd32767 : q);
  endfunction

  // full camera ray: pixel -> NDC -> eye -> pitch -> yaw -> normalize
  function automatic out_item_t trace_ray(in_item_t px);
    longint w, h, one, cp, sp, cy, sn, ndx, ndy, ex, ey, ez;
    longint y1, z1, x2, z2, m, len;
    int k;
    out_item_t d;
    one = longint'(1) << FRAC_BITS;
    w = (vp_w == 0) ? 1 : longint'(vp_w);
    h = (vp_h == 0) ? 1 : longint'(vp_h);
    cp = longint'($signed(cos_pitch));
    sp = longint'($signed(sin_pitch));
    cy = longint'($signed(cos_yaw));
    sn = longint'($signed(sin_yaw));
    ndx = ((longint'(px.screen_x) * 2 * one + w / 2) / w) - one;
    ndy = one - ((longint'(px.screen_y) * 2 * one + h / 2) / h);
    ex = rnd_sh(ndx * longint'(h_scale), 12);
    ey = rnd_sh(ndy * longint'(v_scale), 12);
    ez = -one;
    y1 = rnd_sh(cp * ey + sp * ez, 15);
    z1 = rnd_sh(cp * ez - sp * ey, 15);
    x2 = rnd_sh(cy * ex - sn * z1, 15);
    z2 = rnd_sh(sn * ex + cy * z1, 15);
    m = absl(x2);
    if (absl(y1) > m) m = absl(y1);
    if (absl(z2) > m) m = absl(z2);
    k = 0;
    while ((m >> k) >= (longint'(1) << 30)) k++;
    if (k > 0) begin
      x2 = rnd_sh(x2, k);
      y1 = rnd_sh(y1, k);
      z2 = rnd_sh(z2, k);
    end
    len = int_sqrt(x2 * x2 + y1 * y1 + z2 * z2);
    if (len == 0) return '0;   // degenerate trig gives a null ray
    d.dir_x = unit_comp(x2, len);
    d.dir_y = unit_comp(y1, len);
    d.dir_z = unit_comp(z2, len);
    return d;
  endfunction

  // Single sampling point: accepted pixels, register writes and results
  // are all seen here at the rising edge.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      vp_w <= RST_VW; vp_h <= RST_VH; h_scale <= RST_HS; v_scale <= RST_VS;
      cos_pitch <= RST_CP; sin_pitch <= RST_SP; cos_yaw <= RST_CY;
      sin_yaw <= RST_SY;
    end else begin
      if (out_valid) begin
        if (dir_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected ray %0d %0d %0d", out_data.dir_x,
                     out_data.dir_y, out_data.dir_z);
        end else begin
          want = dir_expected.pop_front();
          if (out_data !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ray mismatch: exp %0d %0d %0d got %0d %0d %0d",
                       want.dir_x, want.dir_y, want.dir_z,
                       out_data.dir_x, out_data.dir_y, out_data.dir_z);
          end
        end
      end
      // trace with registers as they stand before any write this edge
      if (start && !busy) begin
        dir_expected.push_back(drv_typed ? drv_dir : trace_ray(in_data));
        pix_taken++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_VW: vp_w      <= cfg_data[VP_W-1:0];
          REG_VH: vp_h      <= cfg_data[VP_W-1:0];
          REG_HS: h_scale   <= cfg_data;
          REG_VS: v_scale   <= cfg_data;
          REG_CP: cos_pitch <= cfg_data;
          REG_SP: sin_pitch <= cfg_data;
          REG_CY: cos_yaw   <= cfg_data;
          REG_SY: sin_yaw   <= cfg_data;
          default: ;
        endcase
        cfg_taken++;
      end
    end
  end

  // watchdog: no pixel, result or register write for too long
  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy) || (cfg_valid && cfg_ready))
      idle_cyc <= 0;
    else if (idle_cyc >= WDOG_LIM) begin
      $display("RESULT: ERROR");
      $finish;
    end else
      idle_cyc <= idle_cyc + 1;
  end

  // Called at a falling edge, returns at a falling edge. A zero gap keeps
  // start high straight into the next item.
  task automatic drive_pixel(in_item_t px, logic typed, out_item_t dir);
    int unsigned gap, n;
    gap = $urandom_range(0, 5);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_data <= px;
    drv_typed <= typed;
    drv_dir <= dir;
    n = pix_taken;
    wait (pix_taken != n);
    @(negedge clk);
  endtask

  // register writes only with the pipe drained
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
    int unsigned n;
    start <= 1'b0;
    wait (dir_expected.size() == 0);
    repeat (DRAIN_CYC) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    n = cfg_taken;
    wait (cfg_taken != n);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  row_t dir_rows[] = '{
    // reset settings, screen center: straight ahead, pitched 30 degrees
    '{ROW_PIX, REG_VW, 16'd0, '{12'd512, 12'd384}, 1'b1,
      '{16'sd0, -16'sd16385, -16'sd28378}},
    '{ROW_PIX, REG_VW, 16'd0, '{12'd0, 12'd0}, 1'b0, '0},
    '{ROW_PIX, REG_VW, 16'd0, '{12'd4095, 12'd4095}, 1'b0, '0},  // off screen
    '{ROW_PIX, REG_VW, 16'd0, '{12'd1023, 12'd767}, 1'b0, '0},
    '{ROW_PIX, REG_VW, 16'd0, '{12'd4095, 12'd0}, 1'b0, '0},
    // zero viewport counts as one pixel
    '{ROW_CFG, REG_VW, 16'd0, '0, 1'b0, '0},
    '{ROW_CFG, REG_VH, 16'd0, '0, 1'b0, '0},
    '{ROW_PIX, REG_VW, 16'd0, '{12'd0, 12'd0}, 1'b0, '0},
    '{ROW_PIX, REG_VW, 16'd0, '{12'd4095, 12'd4095}, 1'b0, '0},
    '{ROW_PIX, REG_VW, 16'd0, '{12'd1, 12'd1}, 1'b0, '0},
    // 4096x4096 viewport and largest scales
    '{ROW_CFG, REG_VW, 16'd4096, '0, 1'b0, '0},
    '{ROW_CFG, REG_VH, 16'd4096, '0, 1'b0, '0},
    '{ROW_CFG, REG_HS, 16'hFFFF, '0, 1'b0, '0},
    '{ROW_CFG, REG_VS, 16'hFFFF, '0, 1'b0, '0},
    '{ROW_PIX, REG_VW, 16'd0, '{12'd0, 12'd4095}, 1'b0, '0},
    '{ROW_PIX, REG_VW, 16'd0, '{12'd2048, 12'd2048}, 1'b0, '0},
    '{ROW_PIX, REG_VW, 16'd0, '{12'd4095, 12'd0}, 1'b0, '0},
    // zero scales: every ray is the optical axis
    '{ROW_CFG, REG_HS, 16'd0, '0, 1'b0, '0},
    '{ROW_CFG, REG_VS, 16'd0, '0, 1'b0, '0},
    '{ROW_PIX, REG_VW, 16'd0, '{12'd100, 12'd200}, 1'b0, '0},
    // trig extremes, non-unit values used as given
    '{ROW_CFG, REG_CP, 16'h8000, '0, 1'b0, '0},
    '{ROW_CFG, REG_SP, 16'h7FFF, '0, 1'b0, '0},
    '{ROW_CFG, REG_CY, 16'h8000, '0, 1'b0, '0},
    '{ROW_CFG, REG_SY, 16'h7FFF, '0, 1'b0, '0},
    '{ROW_CFG, REG_HS, 16'd4096, '0, 1'b0, '0},
    '{ROW_CFG, REG_VS, 16'd4096, '0, 1'b0, '0},
    '{ROW_PIX, REG_VW, 16'd0, '{12'd0, 12'd0}, 1'b0, '0},
    '{ROW_PIX, REG_VW, 16'd0, '{12'd4095, 12'd4095}, 1'b0, '0},
    '{ROW_PIX, REG_VW, 16'd0, '{12'd1234, 12'd567}, 1'b0, '0},
    // all trig zero: null vector, all-zero direction
    '{ROW_CFG, REG_CP, 16'd0, '0, 1'b0, '0},
    '{ROW_CFG, REG_SP, 16'd0, '0, 1'b0, '0},
    '{ROW_CFG, REG_CY, 16'd0, '0, 1'b0, '0},
    '{ROW_CFG, REG_SY, 16'd0, '0, 1'b0, '0},
    '{ROW_PIX, REG_VW, 16'd0, '{12'd77, 12'd88}, 1'b1, '0},
    '{ROW_PIX, REG_VW, 16'd0, '{12'd4095, 12'd4095}, 1'b1, '0}
  };

  initial begin
    in_item_t px;
    logic [REG_W-1:0] v;
    int unsigned phase_len;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG)
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      else
        drive_pixel(dir_rows[i].px, dir_rows[i].typed, dir_rows[i].dir);
    end

    // random phases: fresh camera each phase, then a burst of pixels
    phase_len = 0;
    for (int i = 0; i < N_RAND; i++) begin
      if (phase_len == 0) begin
        for (int r = 0; r < 8; r++) begin
          if (r < 2)        // viewport: mostly sane, sometimes wild bits
            v = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                            : 16'($urandom_range(1, 4096));
          else if (r < 4)   // scales: mostly near unit fov
            v = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                            : 16'($urandom_range(1024, 12288));
          else
            v = 16'($urandom);
          if ($urandom_range(0, 3) != 0) write_reg(r[CFG_IDX_W-1:0], v);
        end
        phase_len = $urandom_range(20, 120);
      end
      px.screen_x = 12'($urandom);
      px.screen_y = 12'($urandom);
      drive_pixel(px, 1'b0, '0);
      phase_len--;
    end
    start <= 1'b0;

    wait (dir_expected.size() == 0);
    repeat (DRAIN_CYC) @(negedge clk);
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/srp_pkg.sv
hw/rtl/srp_div.sv
hw/rtl/screen_pixel_to_world_ray.sv
tb/sv/tb.sv
